### hdl/mhdf_pkg.sv
// Shared types, constants and fixed-point helpers for the ideal MHD flux pipeline.
`timescale 1ns / 1ps

package mhdf_pkg;

    localparam int DataW   = 32;
    localparam int GammaW  = 18;
    localparam int CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgGasGamma = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgFieldX   = 2'd1;

    localparam logic [GammaW-1:0]      GammaReset = 18'd109227;
    localparam logic signed [18:0]     QOne       = 19'sd65536;
    localparam logic signed [63:0]     HalfLsb16  = 64'sd32768;
    localparam logic signed [63:0]     HalfLsb17  = 64'sd65536;
    localparam logic signed [63:0]     SatMax     = 64'sd2147483647;
    localparam logic signed [63:0]     SatMin     = -64'sd2147483648;

    // Divider: two set-up stages, one stage per quotient bit, one finishing stage
    localparam int DivIters  = 33;
    localparam int DivStages = DivIters + 3;

    // Pipeline stage numbers
    localparam int StgSq      = 1;
    localparam int StgHh      = 2;
    localparam int StgProd    = DivStages;
    localparam int StgSum     = StgProd + 1;
    localparam int StgKinP    = StgProd + 2;
    localparam int StgKin     = StgProd + 3;
    localparam int StgInner   = StgProd + 4;
    localparam int StgPressP  = StgProd + 5;
    localparam int StgPress   = StgProd + 6;
    localparam int StgPtot    = StgProd + 7;
    localparam int StgEp      = StgProd + 8;
    localparam int StgEnP     = StgProd + 9;
    localparam int StgOut     = StgProd + 10;
    localparam int NumStages  = StgOut + 1;

    typedef enum logic [1:0] {
        StOk     = 2'd0,
        StNonPos = 2'd1,
        StSat    = 2'd2
    } status_t;

    // Cell data carried alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [31:0] e;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] hh;
        logic signed [31:0] vx;
        logic               rpos;
        logic               sflag;
    } side_t;

    // Partial fluxes carried towards the output
    typedef struct packed {
        logic signed [31:0] vv;
        logic signed [31:0] bv;
        logic signed [48:0] a1;
        logic signed [31:0] f1;
        logic signed [31:0] f2;
        logic signed [31:0] f3;
        logic signed [31:0] f5;
        logic signed [31:0] f6;
    } mid_t;

    // One step of the restoring divider
    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] low;
        logic [32:0] q;
        logic [32:0] den;
        logic        neg;
        logic        ovf;
    } div_t;

    // Q16.16 product rounding, ties towards plus infinity
    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + HalfLsb16;
        return t[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > SatMax)
            return 32'sh7fffffff;
        else if (x < SatMin)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic sat_hit(input logic signed [63:0] x);
        return (x > SatMax) || (x < SatMin);
    endfunction

endpackage

### hdl/ideal_mhd_flux_unit.sv
// Ideal MHD physical flux unit: top level with configuration registers.
// The pipeline has 47 register stages.
// One item per cycle sustained while flux_stall is low. The depth is set mostly by the 36-stage pipelined
// dividers (33 quotient-bit stages) that form the velocities.
// A held result stalls only the stages ahead of the first bubble, so bubbles fill.
// Reset clears all valid bits; gas_gamma returns to 5/3 and field_x to zero.
`timescale 1ns / 1ps

module ideal_mhd_flux_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mhdf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [31:0]           density,
    input  logic signed [31:0]           mom_x,
    input  logic signed [31:0]           mom_y,
    input  logic signed [31:0]           mom_z,
    input  logic signed [31:0]           energy,
    input  logic signed [31:0]           field_y,
    input  logic signed [31:0]           field_z,
    output logic                         flux_valid,
    input  logic                         flux_stall,
    output logic signed [31:0]           flux_mass,
    output logic signed [31:0]           flux_mom_x,
    output logic signed [31:0]           flux_mom_y,
    output logic signed [31:0]           flux_mom_z,
    output logic signed [31:0]           flux_energy,
    output logic signed [31:0]           flux_field_y,
    output logic signed [31:0]           flux_field_z,
    output logic [1:0]                   status
);
    import mhdf_pkg::*;

    logic [GammaW-1:0]    gamma_reg;
    logic signed [31:0]   bx_reg;
    logic [NumStages-1:0] en;
    logic signed [31:0]   vx, vy, vz;
    logic                 vx_sat, vy_sat, vz_sat;

    // Configuration writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GammaReset;
            bx_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CfgGasGamma: gamma_reg <= cfg_data[GammaW-1:0];
                CfgFieldX:   bx_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    mhdf_ctl u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .flux_valid (flux_valid),
        .flux_stall (flux_stall),
        .en         (en)
    );

    // Velocities v = m / r
    mhdf_div u_div_x (
        .clk      (clk),
        .en       (en[DivStages-1:0]),
        .numer    (mom_x),
        .denom    (density),
        .quot     (vx),
        .quot_sat (vx_sat)
    );

    mhdf_div u_div_y (
        .clk      (clk),
        .en       (en[DivStages-1:0]),
        .numer    (mom_y),
        .denom    (density),
        .quot     (vy),
        .quot_sat (vy_sat)
    );

    mhdf_div u_div_z (
        .clk      (clk),
        .en       (en[DivStages-1:0]),
        .numer    (mom_z),
        .denom    (density),
        .quot     (vz),
        .quot_sat (vz_sat)
    );

    mhdf_flux u_flux (
        .clk          (clk),
        .en           (en),
        .gas_gamma    (gamma_reg),
        .field_x      (bx_reg),
        .density      (density),
        .mom_x        (mom_x),
        .mom_y        (mom_y),
        .mom_z        (mom_z),
        .energy       (energy),
        .field_y      (field_y),
        .field_z      (field_z),
        .vel_x        (vx),
        .vel_y        (vy),
        .vel_z        (vz),
        .vel_sat      (vx_sat | vy_sat | vz_sat),
        .flux_mass    (flux_mass),
        .flux_mom_x   (flux_mom_x),
        .flux_mom_y   (flux_mom_y),
        .flux_mom_z   (flux_mom_z),
        .flux_energy  (flux_energy),
        .flux_field_y (flux_field_y),
        .flux_field_z (flux_field_z),
        .status       (status)
    );

endmodule

### hdl/mhdf_ctl.sv
// Valid bits and per-stage advance enables for the flux pipeline.
`timescale 1ns / 1ps

module mhdf_ctl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    output logic                           flux_valid,
    input  logic                           flux_stall,
    output logic [mhdf_pkg::NumStages-1:0] en
);
    import mhdf_pkg::*;

    logic [NumStages-1:0] valid_reg;

    // A stage advances when the output is not stalled, or when it or any stage after it holds a bubble
    for (genvar k = 0; k < NumStages; k++)
    begin : g_en
        assign en[k] = ~flux_stall | ~(&valid_reg[NumStages-1:k]);
    end

    // Move valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= item_valid;
            for (int k = 1; k < NumStages; k++)
            begin
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign item_stall = ~en[0];
    assign flux_valid = valid_reg[NumStages-1];

endmodule

### hdl/mhdf_div.sv
// Pipelined restoring divider: Q16.16 quotient rounded to nearest, saturated.
`timescale 1ns / 1ps

module mhdf_div (
    input  logic                           clk,
    input  logic [mhdf_pkg::DivStages-1:0] en,
    input  logic signed [31:0]             numer,
    input  logic signed [31:0]             denom,
    output logic signed [31:0]             quot,
    output logic                           quot_sat
);
    import mhdf_pkg::*;

    logic signed [49:0] num_reg;
    logic [32:0]        den0_reg;
    logic [48:0]        mag_reg;
    logic               neg_reg;
    logic [32:0]        den1_reg;
    div_t               it_reg [0:DivIters-1];
    div_t               it_in  [0:DivIters-1];
    div_t               it_out [0:DivIters-1];
    logic signed [31:0] quot_reg;
    logic               sat_reg;

    logic signed [49:0] num_abs;
    logic [33:0]        trial [0:DivIters-1];
    logic [33:0]        diff  [0:DivIters-1];
    logic [32:0]        q_fin;
    logic               rnz;
    logic [33:0]        neg_mag;
    logic [33:0]        neg_val;
    logic signed [31:0] quot_next;
    logic               sat_next;

    // Stage 0: numerator 2*m*2^16 + r over denominator 2*r
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg  <= (50'(numer) <<< 17) + 50'(denom);
            den0_reg <= {denom, 1'b0};
        end
    end

    // Stage 1: take the magnitude
    assign num_abs = num_reg[49] ? -num_reg : num_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag_reg  <= num_abs[48:0];
            neg_reg  <= num_reg[49];
            den1_reg <= den0_reg;
        end
    end

    // One quotient bit per stage
    always_comb
    begin
        it_in[0].rem = 33'(mag_reg[48:33]);
        it_in[0].low = mag_reg[32:0];
        it_in[0].q   = '0;
        it_in[0].den = den1_reg;
        it_in[0].neg = neg_reg;
        it_in[0].ovf = 33'(mag_reg[48:33]) >= den1_reg;
        for (int j = 1; j < DivIters; j++)
            it_in[j] = it_reg[j-1];
        for (int j = 0; j < DivIters; j++)
        begin
            trial[j]      = {it_in[j].rem, it_in[j].low[32]};
            diff[j]       = trial[j] - {1'b0, it_in[j].den};
            it_out[j]     = it_in[j];
            it_out[j].low = {it_in[j].low[31:0], 1'b0};
            if (trial[j] >= {1'b0, it_in[j].den})
            begin
                it_out[j].rem = diff[j][32:0];
                it_out[j].q   = {it_in[j].q[31:0], 1'b1};
            end
            else
            begin
                it_out[j].rem = trial[j][32:0];
                it_out[j].q   = {it_in[j].q[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DivIters; j++)
        begin
            if (en[2+j])
                it_reg[j] <= it_out[j];
        end
    end

    // Finish: floor for negative numerators, then clamp
    assign q_fin   = it_reg[DivIters-1].q;
    assign rnz     = |it_reg[DivIters-1].rem;
    assign neg_mag = 34'(q_fin) + 34'(rnz);
    assign neg_val = ~neg_mag + 34'd1;

    always_comb
    begin
        if (it_reg[DivIters-1].neg)
        begin
            sat_next  = it_reg[DivIters-1].ovf || (neg_mag > 34'h080000000);
            quot_next = sat_next ? 32'sh80000000 : neg_val[31:0];
        end
        else
        begin
            sat_next  = it_reg[DivIters-1].ovf || q_fin[32] || q_fin[31];
            quot_next = sat_next ? 32'sh7fffffff : q_fin[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DivStages-1])
        begin
            quot_reg <= quot_next;
            sat_reg  <= sat_next;
        end
    end

    assign quot     = quot_reg;
    assign quot_sat = sat_reg;

endmodule

### hdl/mhdf_flux.sv
// Pressure and flux datapath with the cell data shift line beside the dividers.
`timescale 1ns / 1ps

module mhdf_flux (
    input  logic                           clk,
    input  logic [mhdf_pkg::NumStages-1:0] en,
    input  logic [mhdf_pkg::GammaW-1:0]    gas_gamma,
    input  logic signed [31:0]             field_x,
    input  logic signed [31:0]             density,
    input  logic signed [31:0]             mom_x,
    input  logic signed [31:0]             mom_y,
    input  logic signed [31:0]             mom_z,
    input  logic signed [31:0]             energy,
    input  logic signed [31:0]             field_y,
    input  logic signed [31:0]             field_z,
    input  logic signed [31:0]             vel_x,
    input  logic signed [31:0]             vel_y,
    input  logic signed [31:0]             vel_z,
    input  logic                           vel_sat,
    output logic signed [31:0]             flux_mass,
    output logic signed [31:0]             flux_mom_x,
    output logic signed [31:0]             flux_mom_y,
    output logic signed [31:0]             flux_mom_z,
    output logic signed [31:0]             flux_energy,
    output logic signed [31:0]             flux_field_y,
    output logic signed [31:0]             flux_field_z,
    output logic [1:0]                     status
);
    import mhdf_pkg::*;

    side_t side_reg  [0:StgOut-1];
    side_t side_next [0:StgOut-1];
    mid_t  mid_reg   [StgSum:StgOut-1];
    mid_t  mid_next  [StgSum:StgOut-1];
    logic [NumStages-1:0] hit;

    logic signed [63:0] sqbx_reg, sqby_reg, sqbz_reg;
    logic signed [63:0] pmx_reg, pmy_reg, pmz_reg, pby_reg, pbz_reg;
    logic signed [63:0] pvybx_reg, pvzbx_reg, pbxvx_reg, pbyvy_reg, pbzvz_reg;
    logic signed [63:0] pvx2_reg, pvy2_reg, pvz2_reg, pbxby_reg, pbxbz_reg, pbx2_reg;
    logic signed [63:0] kinp_reg, pressp_reg, pep_reg, pbv_reg;
    logic signed [31:0] kin_reg, inner_reg, press_reg, ptot_reg, ep_reg;
    logic signed [31:0] fm_reg, f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    status_t            status_reg;

    logic signed [63:0] hh_sum, vv_sum, bv_sum, f2_sum, f3_sum, f5_sum, f6_sum;
    logic signed [48:0] a1_val;
    logic signed [63:0] kin_t, kin_sum, inner_sum, press_sum, ptot_sum;
    logic signed [63:0] ep_sum, f1_sum, f4_sum;
    logic [32:0]        hh_inc_a, hh_inc_b;
    logic signed [31:0] hhh_a, hhh_b;
    logic signed [18:0] gm1;
    logic               out_sat;

    // Shift the cell data, adding flags and late values where they appear
    always_comb
    begin
        side_next[0].r     = density;
        side_next[0].mx    = mom_x;
        side_next[0].my    = mom_y;
        side_next[0].mz    = mom_z;
        side_next[0].e     = energy;
        side_next[0].by    = field_y;
        side_next[0].bz    = field_z;
        side_next[0].hh    = '0;
        side_next[0].vx    = '0;
        side_next[0].rpos  = density > 32'sd0;
        side_next[0].sflag = 1'b0;
        for (int k = 1; k < StgOut; k++)
        begin
            side_next[k]       = side_reg[k-1];
            side_next[k].sflag = side_reg[k-1].sflag | hit[k];
        end
        side_next[StgHh].hh   = sat32(hh_sum);
        side_next[StgProd].vx = vel_x;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < StgOut; k++)
        begin
            if (en[k])
                side_reg[k] <= side_next[k];
        end
    end

    // Saturation seen at the stages that can saturate
    always_comb
    begin
        hit            = '0;
        hit[StgHh]     = sat_hit(hh_sum);
        hit[StgProd]   = vel_sat;
        hit[StgSum]    = sat_hit(vv_sum) | sat_hit(bv_sum) | sat_hit(f2_sum)
                       | sat_hit(f3_sum) | sat_hit(f5_sum) | sat_hit(f6_sum);
        hit[StgKin]    = sat_hit(kin_sum);
        hit[StgInner]  = sat_hit(inner_sum);
        hit[StgPress]  = sat_hit(press_sum);
        hit[StgPtot]   = sat_hit(ptot_sum);
        hit[StgEp]     = sat_hit(ep_sum) | sat_hit(f1_sum);
        hit[StgOut]    = sat_hit(f4_sum);
    end

    // Squares of the field for |B|^2
    always_ff @(posedge clk)
    begin
        if (en[StgSq])
        begin
            sqbx_reg <= 64'(field_x) * 64'(field_x);
            sqby_reg <= 64'(side_reg[StgSq-1].by) * 64'(side_reg[StgSq-1].by);
            sqbz_reg <= 64'(side_reg[StgSq-1].bz) * 64'(side_reg[StgSq-1].bz);
        end
    end

    assign hh_sum = 64'(rnd16(sqbx_reg)) + 64'(rnd16(sqby_reg)) + 64'(rnd16(sqbz_reg));

    // Products of velocities with momenta, fields and velocities, and of field_x with the field
    always_ff @(posedge clk)
    begin
        if (en[StgProd])
        begin
            pmx_reg   <= 64'(side_reg[StgProd-1].mx) * 64'(vel_x);
            pmy_reg   <= 64'(side_reg[StgProd-1].my) * 64'(vel_x);
            pmz_reg   <= 64'(side_reg[StgProd-1].mz) * 64'(vel_x);
            pby_reg   <= 64'(side_reg[StgProd-1].by) * 64'(vel_x);
            pbz_reg   <= 64'(side_reg[StgProd-1].bz) * 64'(vel_x);
            pvybx_reg <= 64'(vel_y) * 64'(field_x);
            pvzbx_reg <= 64'(vel_z) * 64'(field_x);
            pbxvx_reg <= 64'(field_x) * 64'(vel_x);
            pbyvy_reg <= 64'(side_reg[StgProd-1].by) * 64'(vel_y);
            pbzvz_reg <= 64'(side_reg[StgProd-1].bz) * 64'(vel_z);
            pvx2_reg  <= 64'(vel_x) * 64'(vel_x);
            pvy2_reg  <= 64'(vel_y) * 64'(vel_y);
            pvz2_reg  <= 64'(vel_z) * 64'(vel_z);
            pbxby_reg <= 64'(field_x) * 64'(side_reg[StgProd-1].by);
            pbxbz_reg <= 64'(field_x) * 64'(side_reg[StgProd-1].bz);
            pbx2_reg  <= 64'(field_x) * 64'(field_x);
        end
    end

    // Round and sum the products
    assign vv_sum = 64'(rnd16(pvx2_reg)) + 64'(rnd16(pvy2_reg)) + 64'(rnd16(pvz2_reg));
    assign bv_sum = 64'(rnd16(pbxvx_reg)) + 64'(rnd16(pbyvy_reg)) + 64'(rnd16(pbzvz_reg));
    assign f2_sum = 64'(rnd16(pmy_reg)) - 64'(rnd16(pbxby_reg));
    assign f3_sum = 64'(rnd16(pmz_reg)) - 64'(rnd16(pbxbz_reg));
    assign f5_sum = 64'(rnd16(pby_reg)) - 64'(rnd16(pvybx_reg));
    assign f6_sum = 64'(rnd16(pbz_reg)) - 64'(rnd16(pvzbx_reg));
    assign a1_val = 49'(rnd16(pmx_reg)) - 49'(rnd16(pbx2_reg));

    always_comb
    begin
        mid_next[StgSum].vv = sat32(vv_sum);
        mid_next[StgSum].bv = sat32(bv_sum);
        mid_next[StgSum].a1 = a1_val;
        mid_next[StgSum].f1 = '0;
        mid_next[StgSum].f2 = sat32(f2_sum);
        mid_next[StgSum].f3 = sat32(f3_sum);
        mid_next[StgSum].f5 = sat32(f5_sum);
        mid_next[StgSum].f6 = sat32(f6_sum);
        for (int k = StgSum + 1; k < StgOut; k++)
            mid_next[k] = mid_reg[k-1];
        mid_next[StgEp].f1 = sat32(f1_sum);
    end

    always_ff @(posedge clk)
    begin
        for (int k = StgSum; k < StgOut; k++)
        begin
            if (en[k])
                mid_reg[k] <= mid_next[k];
        end
    end

    // Kinetic energy r|v|^2/2
    assign kin_t   = kinp_reg + HalfLsb17;
    assign kin_sum = kin_t >>> 17;

    // |B|^2/2 rounded up on ties
    assign hh_inc_a = {1'b0, side_reg[StgInner-1].hh} + 33'd1;
    assign hhh_a    = hh_inc_a[32:1];
    assign hh_inc_b = {1'b0, side_reg[StgPtot-1].hh} + 33'd1;
    assign hhh_b    = hh_inc_b[32:1];

    assign inner_sum = 64'(side_reg[StgInner-1].e) - 64'(kin_reg) - 64'(hhh_a);
    assign gm1       = $signed({1'b0, gas_gamma}) - QOne;
    assign press_sum = 64'(rnd16(pressp_reg));
    assign ptot_sum  = 64'(press_reg) + 64'(hhh_b);
    assign ep_sum    = 64'(side_reg[StgEp-1].e) + 64'(ptot_reg);
    assign f1_sum    = 64'(mid_reg[StgEp-1].a1) + 64'(ptot_reg);
    assign f4_sum    = 64'(rnd16(pep_reg)) - 64'(rnd16(pbv_reg));

    // Pressure chain, one step a stage
    always_ff @(posedge clk)
    begin
        if (en[StgKinP])
            kinp_reg <= 64'(side_reg[StgKinP-1].r) * 64'(mid_reg[StgKinP-1].vv);
        if (en[StgKin])
            kin_reg <= sat32(kin_sum);
        if (en[StgInner])
            inner_reg <= sat32(inner_sum);
        if (en[StgPressP])
            pressp_reg <= 64'(gm1) * 64'(inner_reg);
        if (en[StgPress])
            press_reg <= sat32(press_sum);
        if (en[StgPtot])
            ptot_reg <= sat32(ptot_sum);
        if (en[StgEp])
            ep_reg <= sat32(ep_sum);
        if (en[StgEnP])
        begin
            pep_reg <= 64'(ep_reg) * 64'(side_reg[StgEnP-1].vx);
            pbv_reg <= 64'(field_x) * 64'(mid_reg[StgEnP-1].bv);
        end
    end

    // Output register: zero fluxes for a non-positive density
    assign out_sat = side_reg[StgOut-1].sflag | hit[StgOut];

    always_ff @(posedge clk)
    begin
        if (en[StgOut])
        begin
            if (!side_reg[StgOut-1].rpos)
            begin
                fm_reg     <= '0;
                f1_reg     <= '0;
                f2_reg     <= '0;
                f3_reg     <= '0;
                f4_reg     <= '0;
                f5_reg     <= '0;
                f6_reg     <= '0;
                status_reg <= StNonPos;
            end
            else
            begin
                fm_reg     <= side_reg[StgOut-1].mx;
                f1_reg     <= mid_reg[StgOut-1].f1;
                f2_reg     <= mid_reg[StgOut-1].f2;
                f3_reg     <= mid_reg[StgOut-1].f3;
                f4_reg     <= sat32(f4_sum);
                f5_reg     <= mid_reg[StgOut-1].f5;
                f6_reg     <= mid_reg[StgOut-1].f6;
                status_reg <= out_sat ? StSat : StOk;
            end
        end
    end

    assign flux_mass    = fm_reg;
    assign flux_mom_x   = f1_reg;
    assign flux_mom_y   = f2_reg;
    assign flux_mom_z   = f3_reg;
    assign flux_energy  = f4_reg;
    assign flux_field_y = f5_reg;
    assign flux_field_z = f6_reg;
    assign status       = status_reg;

endmodule
